// ----- hw/rtl/sdiv_pkg.sv -----
// shared types and constants for the signed divider
// no dependencies; used by sdiv_cell, sdiv_ctrl and signed_int32_divider
package sdiv_pkg;

  localparam int DATA_BITS     = 32;
  localparam int CNT_BITS      = $clog2(DATA_BITS);
  localparam int IN_TDATA_BITS = ((2 * DATA_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } state_t;

  // controls shared by every cell of the row
  typedef struct packed {
    logic load;
    logic step;
    logic sub;
  } cell_ctrl_t;

  // sequencer outputs toward the datapath
  typedef struct packed {
    logic in_ready;
    logic load;
    logic step;
    logic out_load;
  } seq_t;

endpackage

// ----- hw/rtl/signed_int32_divider.sv -----
// signed 32-bit divider, quotient truncated toward zero, top level
// each item is loaded when accepted, stepped through the cell row at one quotient bit per cycle,
// then sign fixed up into the output register once that is free; no new item is taken while one
// is in the row, but the next item is taken while a result waits
// reset: rst_n synchronous, active low; clears the sequencer and the output valid flag
// depends on sdiv_pkg, sdiv_cell and sdiv_ctrl
module signed_int32_divider (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [sdiv_pkg::IN_TDATA_BITS-1:0]   in_tdata,   // num_in, den_in
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sdiv_pkg::OUT_TDATA_BITS-1:0]  out_tdata,  // quot_out
  output logic [0:0]                           out_tuser   // zero_den
);

  localparam int W = sdiv_pkg::DATA_BITS;

  sdiv_pkg::seq_t     seq;
  sdiv_pkg::cell_ctrl_t cctrl;

  logic [W-1:0] num;
  logic [W-1:0] den;
  logic [W-1:0] num_mag;
  logic [W-1:0] den_mag;
  logic         num_neg;
  logic         den_neg;

  // per-cell wires; the row has one extra cell for the remainder sign
  logic [W:0]   rem_w;
  logic [W:0]   dq_w;
  logic [W:0]   sum_w;
  logic [W+1:0] carry_w;
  logic [W:0]   ld_dq_w;
  logic [W:0]   ld_dv_w;

  // per-item flags captured at accept
  logic qneg_r;
  logic zero_r;
  logic ovf_r;

  // output register
  logic         out_tvalid_r;
  logic [W-1:0] out_quot_r;
  logic         out_zero_r;
  logic [W-1:0] quot_fix;
  logic         out_free;

  // unpack the input item
  assign num = in_tdata[W-1:0];
  assign den = in_tdata[2*W-1:W];

  // magnitudes; the most negative value maps to 2^(W-1) which fits unsigned
  assign num_neg = num[W-1];
  assign den_neg = den[W-1];
  assign num_mag = num_neg ? (~num + 1'b1) : num;
  assign den_mag = den_neg ? (~den + 1'b1) : den;

  // sequencer
  assign out_free = !out_tvalid_r || out_tready;

  sdiv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .out_free  (out_free),
    .seq       (seq)
  );

  assign in_tready = seq.in_ready;

  // non-restoring step: subtract while the remainder is non-negative, add otherwise
  assign cctrl.load = seq.load;
  assign cctrl.step = seq.step;
  assign cctrl.sub  = !rem_w[W];

  // load values: dividend into the quotient shift slices, divisor into all but the top cell
  assign ld_dq_w = {1'b0, num_mag};
  assign ld_dv_w = {1'b0, den_mag};
  assign carry_w[0] = cctrl.sub;

  // row of bit-slice cells: remainder and dividend shift up one cell per step,
  // the dividend top bit enters the remainder bottom, the new quotient bit enters
  // the dividend bottom
  for (genvar i = 0; i <= W; i++) begin : g_cell
    logic rem_in_b;
    logic dq_in_b;

    if (i == 0) begin : g_bottom
      assign rem_in_b = dq_w[W-1];
      assign dq_in_b  = !sum_w[W];
    end else begin : g_upper
      assign rem_in_b = rem_w[i-1];
      assign dq_in_b  = dq_w[i-1];
    end

    sdiv_cell u_cell (
      .clk       (clk),
      .ctrl      (cctrl),
      .ld_dq     (ld_dq_w[i]),
      .ld_dv     (ld_dv_w[i]),
      .rem_in    (rem_in_b),
      .dq_in     (dq_in_b),
      .carry_in  (carry_w[i]),
      .rem_q     (rem_w[i]),
      .dq_q      (dq_w[i]),
      .sum       (sum_w[i]),
      .carry_out (carry_w[i+1])
    );
  end

  // special cases and sign, kept for the fix-up
  always_ff @(posedge clk) begin
    if (seq.load) begin
      qneg_r <= num_neg ^ den_neg;
      zero_r <= (den == '0);
      ovf_r  <= (num == {1'b1, {(W-1){1'b0}}}) && (den == {W{1'b1}});
    end
  end

  // sign fix-up with zero divisor and overflow overrides
  always_comb begin
    if (zero_r) begin
      quot_fix = '0;
    end else if (ovf_r) begin
      quot_fix = {1'b0, {(W-1){1'b1}}};
    end else if (qneg_r) begin
      quot_fix = ~dq_w[W-1:0] + 1'b1;
    end else begin
      quot_fix = dq_w[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (seq.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.out_load) begin
      out_quot_r <= quot_fix;
      out_zero_r <= zero_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = sdiv_pkg::OUT_TDATA_BITS'(out_quot_r);
  assign out_tuser  = out_zero_r;

  a_zero_quot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_zero_r |-> out_quot_r == '0)
    else $error("zero divisor with nonzero quotient");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    seq.out_load |-> !out_tvalid_r || out_tready)
    else $error("result overwrote a waiting item");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    seq.out_load |=> out_tvalid_r)
    else $error("loaded result not presented");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !seq.step && !seq.out_load)
    else $error("input ready while an item is in the row");

endmodule

// ----- hw/rtl/sdiv_cell.sv -----
// one bit slice of the divider row: remainder bit, dividend/quotient bit, divisor bit
// depends on sdiv_pkg for the cell control struct
module sdiv_cell (
  input  logic                  clk,
  input  sdiv_pkg::cell_ctrl_t  ctrl,
  input  logic                  ld_dq,
  input  logic                  ld_dv,
  input  logic                  rem_in,
  input  logic                  dq_in,
  input  logic                  carry_in,
  output logic                  rem_q,
  output logic                  dq_q,
  output logic                  sum,
  output logic                  carry_out
);

  logic rem_r;
  logic dq_r;
  logic dv_r;
  logic dop;

  // add or subtract the divisor bit against the shifted remainder bit
  assign dop       = dv_r ^ ctrl.sub;
  assign sum       = rem_in ^ dop ^ carry_in;
  assign carry_out = (rem_in & dop) | (carry_in & (rem_in ^ dop));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_r <= 1'b0;
      dq_r  <= ld_dq;
      dv_r  <= ld_dv;
    end else if (ctrl.step) begin
      rem_r <= sum;
      dq_r  <= dq_in;
    end
  end

  assign rem_q = rem_r;
  assign dq_q  = dq_r;

endmodule

// ----- hw/rtl/sdiv_ctrl.sv -----
// sequencer for the divider: accept, step count, result hand-off
// depends on sdiv_pkg for state and control types
module sdiv_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           out_free,
  output sdiv_pkg::seq_t seq
);

  sdiv_pkg::state_t                state_r;
  sdiv_pkg::state_t                state_nxt;
  logic [sdiv_pkg::CNT_BITS-1:0]   cnt_r;
  logic [sdiv_pkg::CNT_BITS-1:0]   cnt_nxt;
  logic                            last_step;

  assign last_step = (cnt_r == sdiv_pkg::CNT_BITS'(sdiv_pkg::DATA_BITS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      sdiv_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) begin
          state_nxt = sdiv_pkg::ST_RUN;
        end
      end
      sdiv_pkg::ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = sdiv_pkg::ST_FIX;
        end
      end
      sdiv_pkg::ST_FIX: begin
        if (out_free) begin
          state_nxt = sdiv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sdiv_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    seq = '0;
    case (state_r)
      sdiv_pkg::ST_IDLE: begin
        seq.in_ready = 1'b1;
        seq.load     = in_tvalid;
      end
      sdiv_pkg::ST_RUN: begin
        seq.step = 1'b1;
      end
      sdiv_pkg::ST_FIX: begin
        seq.out_load = out_free;
      end
      default: begin
        seq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdiv_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_load_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(seq.load && seq.step))
    else $error("load and step together");

  a_run_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    seq.load |=> (state_r == sdiv_pkg::ST_RUN) && (cnt_r == '0))
    else $error("accepted item did not start stepping at count zero");

  a_fix_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sdiv_pkg::ST_RUN) && last_step |=> state_r == sdiv_pkg::ST_FIX)
    else $error("step count overran");

endmodule

// ----- dv/signed_int32_divider_test.sv -----
// self-checking testbench for signed_int32_divider: directed table then random operands,
// each result checked against a typed-in value or a truncating signed divide worked out in the bench
// depends on sdiv_pkg and the signed_int32_divider rtl
module signed_int32_divider_test;

  localparam int W = sdiv_pkg::DATA_BITS;
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = ~MOST_NEG;
  localparam logic [W-1:0] ALL_ONES = '1;

  // directed row kinds: result typed in, or left to the quotient predictor
  localparam bit TYPED   = 1'b1;
  localparam bit PREDICT = 1'b0;

  localparam int RANDOM_ITEMS   = 1900;
  localparam int RANDOM_PHASES  = 10;
  localparam int BURST_ITEMS    = 12;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off, well past the time one item takes
  localparam int DRAIN_CYCLES   = 40;    // drain time, longer than the latency of an item
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side

  typedef struct packed {
    logic [W-1:0] quot;
    logic         zero_den;
  } quot_item_t;

  typedef struct packed {
    logic [W-1:0] num;
    logic [W-1:0] den;
    bit           kind;
    logic [W-1:0] quot;
    logic         zero_den;
  } div_row_t;

  // clock, reset and dut ports; the bench-driven ones are known from time zero
  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [sdiv_pkg::IN_TDATA_BITS-1:0]  in_tdata = '0;   // num_in, den_in
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [sdiv_pkg::OUT_TDATA_BITS-1:0] out_tdata;       // quot_out
  logic [0:0]                          out_tuser;       // zero_den

  quot_item_t pending_quots[$];
  int         mismatches = 0;
  bit         tx_idle = 1'b1;   // sender inserts random gaps
  bit         rx_idle = 1'b1;   // receiver inserts random stalls
  bit         hold_output = 1'b0;

  // directed items: extremes, sign combinations, zero divisor, overflow, powers of two
  div_row_t div_rows [24] = '{
    '{'0,           32'sd5,      TYPED,   '0,          1'b0},  // zero dividend
    '{32'sd7,       '0,          TYPED,   '0,          1'b1},  // zero divisor
    '{'0,           '0,          TYPED,   '0,          1'b1},
    '{MOST_NEG,     '0,          TYPED,   '0,          1'b1},
    '{MOST_NEG,     ALL_ONES,    TYPED,   MOST_POS,    1'b0},  // overflow saturates
    '{MOST_NEG,     32'sd1,      TYPED,   MOST_NEG,    1'b0},
    '{MOST_POS,     32'sd1,      TYPED,   MOST_POS,    1'b0},
    '{MOST_POS,     ALL_ONES,    TYPED,   MOST_NEG + 1, 1'b0},
    '{MOST_NEG,     MOST_NEG,    TYPED,   32'sd1,      1'b0},
    '{MOST_POS,     MOST_POS,    TYPED,   32'sd1,      1'b0},
    '{MOST_POS,     MOST_NEG,    TYPED,   '0,          1'b0},
    '{MOST_NEG,     MOST_POS,    TYPED,   ALL_ONES,    1'b0},
    '{ALL_ONES,     MOST_NEG,    TYPED,   '0,          1'b0},
    '{-32'sd7,      32'sd2,      PREDICT, '0,          1'b0},
    '{32'sd7,       -32'sd2,     PREDICT, '0,          1'b0},
    '{-32'sd7,      -32'sd2,     PREDICT, '0,          1'b0},
    '{-32'sd9,      32'sd4,      PREDICT, '0,          1'b0},  // power of two, inexact
    '{32'sd9,       -32'sd4,     PREDICT, '0,          1'b0},
    '{-32'sd8,      32'sd4,      PREDICT, '0,          1'b0},
    '{MOST_NEG,     32'sd2,      PREDICT, '0,          1'b0},
    '{MOST_NEG,     -32'sd2,     PREDICT, '0,          1'b0},
    '{32'sd1,       ALL_ONES,    PREDICT, '0,          1'b0},
    '{32'h5555_5555, 32'h0000_0003, PREDICT, '0,       1'b0},
    '{32'hAAAA_AAAA, 32'h5555_5555, PREDICT, '0,       1'b0}
  };

  signed_int32_divider dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // quotient truncated toward zero on magnitudes, sign applied afterwards; zero divisor and overflow first
  function automatic quot_item_t trunc_divide(input logic [W-1:0] num,
                                              input logic [W-1:0] den);
    quot_item_t   res;
    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;
    res.quot     = '0;
    res.zero_den = 1'b0;
    if (den == '0) begin
      res.zero_den = 1'b1;
    end else if (num == MOST_NEG && den == ALL_ONES) begin
      res.quot = MOST_POS;
    end else begin
      num_mag  = num[W-1] ? -num : num;
      den_mag  = den[W-1] ? -den : den;
      res.quot = num_mag / den_mag;
      if (num[W-1] != den[W-1]) res.quot = -res.quot;
    end
    return res;
  endfunction

  // operand mix: full range, small values, powers of two, extremes, varied magnitude
  function automatic logic [W-1:0] random_operand();
    logic [W-1:0] v;
    bit           flip;
    flip = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        v    = $urandom;
        flip = 1'b0;
      end
      4: begin
        v    = $urandom_range(0, 200) - 100;
        flip = 1'b0;
      end
      5: v = 1 << $urandom_range(0, W - 1);
      6: begin
        flip = 1'b0;
        case ($urandom_range(0, 4))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = '0;
          3: v = ALL_ONES;
          default: v = 1;
        endcase
      end
      7: v = $urandom_range(0, 65535);
      default: v = $urandom >> $urandom_range(0, W - 1);
    endcase
    if (flip) v = -v;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // offer one item after a random gap when tx_idle is set, hold it until taken, then queue its quotient
  task automatic send_item(input logic [W-1:0] num, input logic [W-1:0] den,
                           input quot_item_t want);
    int gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {den, num};
    do @(posedge clk); while (!in_tready);
    pending_quots.push_back(want);
  endtask

  task automatic quiet_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // stimulus sequence
  initial begin
    logic [W-1:0] num;
    logic [W-1:0] den;
    quot_item_t   want;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (div_rows[i]) begin
      want = (div_rows[i].kind == TYPED) ? quot_item_t'({div_rows[i].quot, div_rows[i].zero_den})
                                         : trunc_divide(div_rows[i].num, div_rows[i].den);
      send_item(div_rows[i].num, div_rows[i].den, want);
    end

    // sender pauses until the block has drained
    quiet_input();
    wait (pending_quots.size() == 0);

    // back to back items against a long receiver hold-off, input side must stall
    hold_output = 1'b1;
    tx_idle     = 1'b0;
    repeat (BURST_ITEMS) begin
      num = random_operand();
      den = random_operand();
      send_item(num, den, trunc_divide(num, den));
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // first phase idles both sides, second none, the rest are drawn
      tx_idle = (phase == 0) || (phase > 1 && $urandom_range(0, 3) != 0);
      rx_idle = (phase == 0) || (phase > 1 && $urandom_range(0, 3) != 0);
      repeat (RANDOM_ITEMS / RANDOM_PHASES) begin
        num = random_operand();
        den = ($urandom_range(0, 39) == 0) ? '0 : random_operand();
        if ($urandom_range(0, 99) == 0) begin
          num = MOST_NEG;
          den = ALL_ONES;
        end
        send_item(num, den, trunc_divide(num, den));
      end
    end

    quiet_input();
    wait (pending_quots.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: random stalls per item when rx_idle is set, one long hold-off on request
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end
      gap = rx_idle ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // result check against the oldest queued quotient
  always @(posedge clk) begin
    quot_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_quots.size() == 0) begin
        report_mismatch($sformatf("unexpected item quot=%h zero_den=%b",
                                  out_tdata[W-1:0], out_tuser[0]));
      end else begin
        want = pending_quots.pop_front();
        if (out_tdata[W-1:0] !== want.quot)
          report_mismatch($sformatf("quot_out %h, want %h", out_tdata[W-1:0], want.quot));
        if (out_tuser[0] !== want.zero_den)
          report_mismatch($sformatf("zero_den %b, want %b", out_tuser[0], want.zero_den));
      end
    end
  end

  // watchdog on cycles where no item moves on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: timeout after %0d idle cycles", WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

endmodule
